FILE: rtl/greedy_box_suppression_macros.svh
// Assertion macros for the greedy box suppression block.
// Included by modules that check their own control logic.
`ifndef GREEDY_BOX_SUPPRESSION_MACROS_SVH
`define GREEDY_BOX_SUPPRESSION_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define GBS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

FILE: rtl/gbs_pkg.sv
// Package for greedy box suppression: payload structs, widths and defaults.
// No dependencies.
`timescale 1ns / 1ps
package gbs_pkg;
  localparam int unsigned MaxKeptDefault  = 64;
  localparam int unsigned MaxBoxesDefault = 4096;
  localparam logic [15:0] IouResetValue   = 16'd29491;

  typedef struct packed {
    logic               first_of_frame;
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic        [15:0] box_width;
    logic        [15:0] box_height;
  } gbs_in_t;

  typedef struct packed {
    logic        keep;
    logic [11:0] box_index;
    logic        store_full;
  } gbs_out_t;

  // Stored form of a kept box.
  typedef struct packed {
    logic signed [17:0] left;
    logic signed [17:0] top;
    logic signed [17:0] right;
    logic signed [17:0] bottom;
    logic        [31:0] area;
  } gbs_box_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } gbs_state_e;
endpackage

FILE: rtl/gbs_store.sv
// Kept-box memory: one write port, one synchronous read port.
// Depends on gbs_pkg.
`timescale 1ns / 1ps
module gbs_store
  import gbs_pkg::*;
#(
  parameter int unsigned Depth = MaxKeptDefault,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  gbs_box_t      wdata_i,
  input  logic [AW-1:0] raddr_i,
  output gbs_box_t      rdata_o
);
  gbs_box_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/gbs_iou.sv
// Overlap test of the incoming box against one stored box; intersection and area sum are registered.
// Depends on gbs_pkg.
`timescale 1ns / 1ps
module gbs_iou
  import gbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  gbs_box_t    cur_i,
  input  gbs_box_t    kept_i,
  input  logic [15:0] thr_i,
  output logic        valid_o,
  output logic        hit_o
);
  logic [16:0] iw, ih;
  logic signed [17:0] lo_x, hi_x, lo_y, hi_y;
  logic [33:0] inter_q;
  logic [32:0] asum_q;
  logic        v1_q;
  logic [33:0] uni;
  logic [49:0] lhs, rhs;

  always_comb begin
    lo_x = (cur_i.left > kept_i.left) ? cur_i.left : kept_i.left;
    hi_x = (cur_i.right < kept_i.right) ? cur_i.right : kept_i.right;
    lo_y = (cur_i.top > kept_i.top) ? cur_i.top : kept_i.top;
    hi_y = (cur_i.bottom < kept_i.bottom) ? cur_i.bottom : kept_i.bottom;
    iw = (hi_x > lo_x) ? 17'(hi_x - lo_x) : 17'd0;
    ih = (hi_y > lo_y) ? 17'(hi_y - lo_y) : 17'd0;
  end

  always_ff @(posedge clk_i) begin
    inter_q <= 34'(iw) * 34'(ih);
    asum_q  <= 33'(cur_i.area) + 33'(kept_i.area);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_comb begin
    uni = 34'(asum_q) - inter_q;
    lhs = {inter_q, 16'd0};
    rhs = 50'(thr_i) * 50'(uni);
  end

  assign valid_o = v1_q;
  assign hit_o   = (inter_q != '0) && (uni != '0) && (lhs > rhs);
endmodule

FILE: rtl/greedy_box_suppression.sv
// Top level of greedy box suppression: control, counters, config register.
// Depends on gbs_pkg, gbs_store, gbs_iou and the assertion macro header.
//
//   channel  | direction | handshake           | payload
//   in       | input     | in_valid_i/ready_o  | gbs_in_t
//   out      | output    | out_valid_o/ready_i | gbs_out_t
//   cfg      | input     | cfg_valid_i/ready_o | iou threshold, 16 bits
//
// A box checked against the stored entries goes from IDLE, where it is accepted,
// through SCAN, which reads each entry through the single memory read port, and
// DRAIN, which waits for the read data and the overlap unit's register, to DONE,
// which posts the result; with no stored entries it goes from IDLE to DONE.
// Reset clears counters and control and loads the default IoU threshold; stored boxes need no clearing.
// The next box is taken while a result waits; its own result holds in DONE
// until the output register frees up.
`timescale 1ns / 1ps
`include "greedy_box_suppression_macros.svh"
module greedy_box_suppression
  import gbs_pkg::*;
#(
  parameter int unsigned MAX_KEPT  = MaxKeptDefault,
  parameter int unsigned MAX_BOXES = MaxBoxesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  gbs_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output gbs_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  localparam int unsigned AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned CW = $clog2(MAX_KEPT + 1);
  localparam int unsigned IdxLimInt = (MAX_BOXES - 1 > 4095) ? 4095 : MAX_BOXES - 1;
  localparam logic [11:0] IdxLim = 12'(IdxLimInt);
  localparam logic [CW-1:0] KeptMax = CW'(MAX_KEPT);

  gbs_state_e state_q, state_d;
  logic [15:0]   thr_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rptr_q, rptr_d;   // next entry to read
  logic [CW-1:0] issued_q, issued_d; // compares outstanding to return
  logic [11:0]   item_q, item_d, idx_q, idx_d;
  gbs_box_t      cur_q;
  logic          hit_q, hit_d;
  logic          ovalid_q, ovalid_d;
  gbs_out_t      odata_q, odata_d;
  logic          rd_en_q;
  logic          we;
  gbs_box_t      kept_rd;
  logic          cmp_valid, cmp_hit;
  logic          in_xfer, out_xfer;
  logic [CW-1:0] base_count;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;
  assign base_count = in_data_i.first_of_frame ? '0 : count_q;

  // Take a new box whenever idle; a waiting result is held off in DONE.
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= IouResetValue;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_xfer) state_d = (base_count == '0) ? ST_DONE : ST_SCAN;
      ST_SCAN:  if (rptr_q + 1'b1 == count_q) state_d = ST_DRAIN;
      ST_DRAIN: if (issued_q == '0) state_d = ST_DONE;
      ST_DONE:  if (!ovalid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    count_d  = count_q;
    rptr_d   = rptr_q;
    issued_d = issued_q;
    item_d   = item_q;
    idx_d    = idx_q;
    hit_d    = hit_q;
    ovalid_d = ovalid_q;
    odata_d  = odata_q;
    we       = 1'b0;
    if (out_xfer) ovalid_d = 1'b0;
    // Retire one compare per returned result.
    if (cmp_valid) begin
      issued_d = issued_d - 1'b1;
      if (cmp_hit) hit_d = 1'b1;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          count_d  = base_count;
          idx_d    = in_data_i.first_of_frame ? '0 : item_q;
          item_d   = (idx_d < IdxLim) ? idx_d + 1'b1 : idx_d;
          hit_d    = 1'b0;
          rptr_d   = '0;
          issued_d = '0;
        end
      end
      ST_SCAN: begin
        rptr_d   = rptr_q + 1'b1;
        issued_d = issued_d + 1'b1;
      end
      ST_DRAIN: ;
      ST_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          odata_d.keep       = !hit_q;
          odata_d.box_index  = idx_q;
          odata_d.store_full = !hit_q && (count_q == KeptMax);
          if (!hit_q && count_q != KeptMax) begin
            we      = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      rptr_q   <= '0;
      issued_q <= '0;
      item_q   <= '0;
      idx_q    <= '0;
      hit_q    <= 1'b0;
      ovalid_q <= 1'b0;
      rd_en_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rptr_q   <= rptr_d;
      issued_q <= issued_d;
      item_q   <= item_d;
      idx_q    <= idx_d;
      hit_q    <= hit_d;
      ovalid_q <= ovalid_d;
      rd_en_q  <= (state_q == ST_SCAN);
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
    if (in_xfer) begin
      cur_q.left   <= 18'(in_data_i.box_left);
      cur_q.top    <= 18'(in_data_i.box_top);
      cur_q.right  <= 18'(in_data_i.box_left) + 18'({2'b00, in_data_i.box_width});
      cur_q.bottom <= 18'(in_data_i.box_top) + 18'({2'b00, in_data_i.box_height});
      cur_q.area   <= 32'(in_data_i.box_width) * 32'(in_data_i.box_height);
    end
  end

  gbs_store #(.Depth(MAX_KEPT)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (cur_q),
    .raddr_i (rptr_q[AW-1:0]),
    .rdata_o (kept_rd)
  );

  gbs_iou u_iou (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_en_q),
    .cur_i   (cur_q),
    .kept_i  (kept_rd),
    .thr_i   (thr_q),
    .valid_o (cmp_valid),
    .hit_o   (cmp_hit)
  );

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  // Store write only after all compares have returned.
  `GBS_ASSERT(a_wr_drained, clk_i, rst_ni, we |-> (issued_q == '0 && !cmp_valid), "write before drain")
  `GBS_ASSERT(a_count_bound, clk_i, rst_ni, 1'b1 |-> (count_q <= KeptMax), "kept count overflow")
  `GBS_ASSERT(a_full_keep, clk_i, rst_ni, ovalid_q |-> (!odata_q.store_full || odata_q.keep), "full without keep")
  `GBS_ASSERT(a_no_accept_busy, clk_i, rst_ni, (state_q != ST_IDLE) |-> !in_ready_o, "accept while busy")
endmodule
